// ===== src/asm_lex_pkg.sv =====
// Package for the assembly line lexer: sizes, token codes, line phases,
// result record type and the keyword and digit tables.
// Used by assembly_line_lexer; depends on nothing else.
package asm_lex_pkg;

   localparam int MAX_LINE_TOKENS = 4;
   localparam int MAX_WORD_CHARS  = 24;
   localparam int VALUE_BITS      = 16;
   localparam int ACC_W           = VALUE_BITS + 1;
   localparam int LEN_W           = 6;
   localparam int NUM_KW          = 26;
   localparam int NUM_MNEM        = 24;
   localparam int FIFO_DEPTH      = 4;

   localparam logic [ACC_W-1:0] VALUE_LIMIT = {1'b0, {VALUE_BITS{1'b1}}};
   localparam logic [LEN_W-1:0] LEN_MAX     = {LEN_W{1'b1}};

   // token codes
   localparam logic [4:0] T_REG     = 5'd24;
   localparam logic [4:0] T_INDEX   = 5'd25;
   localparam logic [4:0] T_DTM     = 5'd26;
   localparam logic [4:0] T_STM     = 5'd27;
   localparam logic [4:0] T_CONST   = 5'd28;
   localparam logic [4:0] T_INVALID = 5'd29;

   // keyword indexes of the timer words
   localparam int KW_DTM = 24;
   localparam int KW_STM = 25;

   // base slots of the accumulators
   localparam int B_2  = 0;
   localparam int B_8  = 1;
   localparam int B_10 = 2;
   localparam int B_16 = 3;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   typedef enum logic [1:0] {
      PH_MNEM,
      PH_OPER,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic                  kind;
      logic [4:0]            token_type;
      logic [15:0]           token_value;
      logic [2:0]            token_slot;
      logic [3:0]            line_tokens;
      logic                  last;
   } result_type;

   // keyword text, first character in the top byte, zero padded
   function automatic logic [47:0] kw_text(input int k);
      logic [47:0] w;
      case (k)
         0:       w = {"clear", 8'h00};
         1:       w = {"ret", 24'h0};
         2:       w = {"jnat", 16'h0};
         3:       w = {"jmp", 24'h0};
         4:       w = {"call", 16'h0};
         5:       w = {"skpe", 16'h0};
         6:       w = {"skpne", 8'h00};
         7:       w = {"mov", 24'h0};
         8:       w = {"add", 24'h0};
         9:       w = {"or", 32'h0};
         10:      w = {"and", 24'h0};
         11:      w = {"xor", 24'h0};
         12:      w = {"sub", 24'h0};
         13:      w = {"msr", 24'h0};
         14:      w = {"subs", 16'h0};
         15:      w = {"msl", 24'h0};
         16:      w = {"jv0", 24'h0};
         17:      w = {"rand", 16'h0};
         18:      w = {"draw", 16'h0};
         19:      w = {"in", 32'h0};
         20:      w = {"hh5", 24'h0};
         21:      w = {"bcd", 24'h0};
         22:      w = "movout";
         23:      w = {"movin", 8'h00};
         24:      w = {"dtm", 24'h0};
         25:      w = {"stm", 24'h0};
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [LEN_W-1:0] kw_len(input int k);
      logic [LEN_W-1:0] n;
      case (k)
         0, 6, 23:                      n = LEN_W'(5);
         2, 4, 5, 14, 17, 18:           n = LEN_W'(4);
         9, 19:                         n = LEN_W'(2);
         22:                            n = LEN_W'(6);
         default:                       n = LEN_W'(3);
      endcase
      return n;
   endfunction

   // keyword character at a position, zero past the end
   function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
      logic [47:0] w;
      w = kw_text(k);
      case (pos)
         3'd0:    return w[47:40];
         3'd1:    return w[39:32];
         3'd2:    return w[31:24];
         3'd3:    return w[23:16];
         3'd4:    return w[15:8];
         3'd5:    return w[7:0];
         default: return 8'h00;
      endcase
   endfunction

   // hex digit value, NO_DIGIT when not a digit
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
      return NO_DIGIT;
   endfunction

   function automatic logic [4:0] radix_of(input int b);
      case (b)
         B_2:     return 5'd2;
         B_8:     return 5'd8;
         B_10:    return 5'd10;
         default: return 5'd16;
      endcase
   endfunction

   // accumulator times radix plus digit, saturating just above the limit
   function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] a,
                                                 input int b,
                                                 input logic [4:0] d);
      logic [ACC_W+4:0] p;
      logic [ACC_W+4:0] ax;
      ax = (ACC_W+5)'(a);
      case (b)
         B_2:     p = ax << 1;
         B_8:     p = ax << 3;
         B_10:    p = (ax << 3) + (ax << 1);
         default: p = ax << 4;
      endcase
      p = p + (ACC_W+5)'(d);
      if (p > (ACC_W+5)'(VALUE_LIMIT)) return VALUE_LIMIT + ACC_W'(1);
      return p[ACC_W-1:0];
   endfunction

endpackage

// ===== src/assembly_line_lexer.sv =====
// Top level of the assembly line lexer: word tracking, token classification
// and a four-entry result queue. Depends on asm_lex_pkg.

// Takes one character per cycle and sustains one item per clock while req_stall is
// low: all per-word state (keyword match flags, per-base accumulators) is updated
// in the cycle a character is accepted, so a word is classified as soon as it
// ends. An item produces zero, one or two results (token and/or line summary);
// they go into a four-entry queue that drains one result per cycle while rsp_stall
// is low, and req_stall rises while fewer than two queue entries are free. Results
// appear on the rsp side in the cycle after the item that produced them at the earliest.
module assembly_line_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [4:0]  rsp_token_type,
   output logic [15:0] rsp_token_value,
   output logic [2:0]  rsp_token_slot,
   output logic [3:0]  rsp_line_tokens,
   output logic        rsp_last
);
   import asm_lex_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   // word state
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        first_ff, first_in, second_ff, second_in, lastc_ff, lastc_in;
   logic [NUM_KW-1:0] flags_ff, flags_in;
   logic [ACC_W-1:0]  acc_ff [4];
   logic [ACC_W-1:0]  acc_in [4];
   logic [ACC_W-1:0]  prev_ff [4];
   logic [ACC_W-1:0]  prev_in [4];
   logic [3:0]        ok_ff, ok_in, okp_ff, okp_in;
   logic [3:0]        slot_ff, slot_in;
   phase_type         phase_ff, phase_in;

   // word after this character
   logic [LEN_W-1:0]  w_len;
   logic [7:0]        w_first, w_second, w_last;
   logic [NUM_KW-1:0] w_flags;
   logic [ACC_W-1:0]  w_acc [4];
   logic [ACC_W-1:0]  w_prev [4];
   logic [3:0]        w_ok, w_okp;

   logic              accept, sep, eos, add, word_end;
   logic [4:0]        dig;

   // result queue
   result_type        fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pop;

   // results of this item
   result_type        r0, r1;
   logic [1:0]        n_res;

   // classification
   logic              mnem_found;
   logic [4:0]        mnem_code;
   logic              op_ok;
   logic [4:0]        op_type;
   logic [15:0]       op_value;
   logic [3:0]        slot_mid;
   phase_type         phase_mid;

   assign accept    = req_valid && !req_stall;
   assign req_stall = cnt_ff > CNT_W'(FIFO_DEPTH - 2);
   assign sep       = req_ch == " " || req_ch == ";" || req_ch == "," || req_ch == 8'h0a;
   assign eos       = req_end_of_string;
   assign add       = !sep && phase_ff != PH_DONE;
   assign dig       = digit_of(req_ch);

   // add the character to the current word
   always_comb begin
      w_len    = len_ff;
      w_first  = first_ff;
      w_second = second_ff;
      w_last   = lastc_ff;
      w_flags  = flags_ff;
      w_ok     = ok_ff;
      w_okp    = okp_ff;
      for (int b = 0; b < 4; b++) begin
         w_acc[b]  = acc_ff[b];
         w_prev[b] = prev_ff[b];
      end
      if (add) begin
         if (len_ff == '0) w_first = req_ch;
         if (len_ff == LEN_W'(1)) w_second = req_ch;
         w_last = req_ch;
         for (int k = 0; k < NUM_KW; k++) begin
            if (!(len_ff < kw_len(k) && kw_char(k, len_ff[2:0]) == req_ch))
               w_flags[k] = 1'b0;
         end
         w_okp = ok_ff;
         for (int b = 0; b < 4; b++) begin
            w_prev[b] = acc_ff[b];
            if (dig < radix_of(b)) w_acc[b] = acc_step(acc_ff[b], b, dig);
            else w_ok[b] = 1'b0;
         end
         if (len_ff != LEN_MAX) w_len = len_ff + LEN_W'(1);
      end
   end

   assign word_end = (sep || eos) && w_len != '0;

   // mnemonic lookup, first match wins
   always_comb begin
      mnem_found = 1'b0;
      mnem_code  = '0;
      for (int k = NUM_MNEM - 1; k >= 0; k--) begin
         if (w_flags[k] && kw_len(k) == w_len) begin
            mnem_found = 1'b1;
            mnem_code  = 5'(k);
         end
      end
   end

   // operand classification
   always_comb begin
      logic [4:0]       d2;
      logic [ACC_W-1:0] v;
      logic             vok;
      d2       = digit_of(w_second);
      op_ok    = 1'b0;
      op_type  = T_INVALID;
      op_value = '0;
      v        = w_acc[B_10];
      vok      = w_ok[B_10];
      if (w_last == "B") begin
         v = w_prev[B_2]; vok = w_okp[B_2];
      end else if (w_last == "O") begin
         v = w_prev[B_8]; vok = w_okp[B_8];
      end else if (w_last == "H") begin
         v = w_prev[B_16]; vok = w_okp[B_16];
      end
      if (w_len == LEN_W'(2) && w_first == "v") begin
         if (d2 != NO_DIGIT) begin
            op_ok = 1'b1; op_type = T_REG; op_value = 16'(d2);
         end
      end else if (w_len == LEN_W'(1) && w_first == "v") begin
         op_ok = 1'b0;
      end else if (w_first == "I") begin
         op_ok = 1'b1; op_type = T_INDEX;
      end else if (w_flags[KW_DTM] && w_len == kw_len(KW_DTM)) begin
         op_ok = 1'b1; op_type = T_DTM;
      end else if (w_flags[KW_STM] && w_len == kw_len(KW_STM)) begin
         op_ok = 1'b1; op_type = T_STM;
      end else if (vok && v <= VALUE_LIMIT && w_len <= LEN_W'(MAX_WORD_CHARS)) begin
         op_ok = 1'b1; op_type = T_CONST; op_value = v[15:0];
      end
   end

   // next phase and slot
   always_comb begin
      slot_mid  = slot_ff;
      phase_mid = phase_ff;
      if (word_end) begin
         case (phase_ff)
            PH_MNEM: begin
               if (mnem_found) begin
                  slot_mid  = 4'd1;
                  phase_mid = (1 >= MAX_LINE_TOKENS) ? PH_DONE : PH_OPER;
               end else begin
                  slot_mid  = '0;
                  phase_mid = PH_DONE;
               end
            end
            PH_OPER: begin
               if (op_ok) begin
                  slot_mid  = slot_ff + 4'd1;
                  phase_mid = (slot_ff + 4'd1 >= 4'(MAX_LINE_TOKENS)) ? PH_DONE : PH_OPER;
               end else begin
                  phase_mid = PH_DONE;
               end
            end
            default: ;
         endcase
      end
      if (eos && phase_mid == PH_MNEM) slot_mid = '0;
      slot_in  = eos ? '0 : slot_mid;
      phase_in = eos ? PH_MNEM : phase_mid;
   end

   // results of this item
   always_comb begin
      result_type tok, sum;
      logic       has_tok;
      tok         = '0;
      sum         = '0;
      has_tok     = 1'b0;
      if (word_end) begin
         case (phase_ff)
            PH_MNEM: begin
               has_tok        = 1'b1;
               tok.token_type = mnem_found ? mnem_code : T_INVALID;
            end
            PH_OPER: begin
               has_tok         = 1'b1;
               tok.token_type  = op_ok ? op_type : T_INVALID;
               tok.token_value = op_ok ? op_value : '0;
               tok.token_slot  = slot_ff[2:0];
            end
            default: ;
         endcase
      end
      if (eos && phase_mid == PH_MNEM) begin
         has_tok        = 1'b1;
         tok            = '0;
         tok.token_type = T_INVALID;
      end
      sum.kind        = 1'b1;
      sum.last        = 1'b1;
      sum.line_tokens = slot_mid;
      r1    = sum;
      r0    = has_tok ? tok : sum;
      n_res = 2'(has_tok) + 2'(eos);
   end

   // word state after this item
   always_comb begin
      if (word_end || eos) begin
         len_in = '0; first_in = '0; second_in = '0; lastc_in = '0;
         flags_in = '1; ok_in = '1; okp_in = '1;
         for (int b = 0; b < 4; b++) begin
            acc_in[b] = '0; prev_in[b] = '0;
         end
      end else begin
         len_in = w_len; first_in = w_first; second_in = w_second; lastc_in = w_last;
         flags_in = w_flags; ok_in = w_ok; okp_in = w_okp;
         for (int b = 0; b < 4; b++) begin
            acc_in[b] = w_acc[b]; prev_in[b] = w_prev[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; first_ff <= '0; second_ff <= '0; lastc_ff <= '0;
         flags_ff <= '1; ok_ff <= '1; okp_ff <= '1;
         for (int b = 0; b < 4; b++) begin
            acc_ff[b] <= '0; prev_ff[b] <= '0;
         end
         slot_ff  <= '0;
         phase_ff <= PH_MNEM;
      end else if (accept) begin
         len_ff <= len_in; first_ff <= first_in; second_ff <= second_in;
         lastc_ff <= lastc_in; flags_ff <= flags_in; ok_ff <= ok_in; okp_ff <= okp_in;
         for (int b = 0; b < 4; b++) begin
            acc_ff[b] <= acc_in[b]; prev_ff[b] <= prev_in[b];
         end
         slot_ff  <= slot_in;
         phase_ff <= phase_in;
      end
   end

   // result queue
   assign pop   = rsp_valid && !rsp_stall;
   assign wp_in = accept ? wp_ff + PTR_W'(n_res) : wp_ff;
   assign rp_in = pop ? rp_ff + PTR_W'(1) : rp_ff;
   assign cnt_in = cnt_ff + (accept ? CNT_W'(n_res) : '0) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) fifo_ff[wp_ff] <= r0;
      if (accept && n_res == 2'd2) fifo_ff[wp_ff + PTR_W'(1)] <= r1;
   end

   // result ports
   assign rsp_valid       = cnt_ff != '0;
   assign rsp_kind        = fifo_ff[rp_ff].kind;
   assign rsp_token_type  = fifo_ff[rp_ff].token_type;
   assign rsp_token_value = fifo_ff[rp_ff].token_value;
   assign rsp_token_slot  = fifo_ff[rp_ff].token_slot;
   assign rsp_line_tokens = fifo_ff[rp_ff].line_tokens;
   assign rsp_last        = fifo_ff[rp_ff].last;

endmodule

// ===== test/testbench.sv =====
// Testbench for the assembly line lexer: random and directed source lines,
// a token predictor in SystemVerilog and a result checker that compares every field.
// Depends on asm_lex_pkg and assembly_line_lexer.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import asm_lex_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       eos;
   } char_item_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        req_end_of_string;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [4:0]  rsp_token_type;
   logic [15:0] rsp_token_value;
   logic [2:0]  rsp_token_slot;
   logic [3:0]  rsp_line_tokens;
   logic        rsp_last;

   char_item_type pending_chars[$];
   result_type    expected_tokens[$];
   int         mismatches;
   int         results_seen;
   int         lines_sent;
   int         chars_sent;
   bit         stimulus_done;
   bit         quiet_phase;
   int         send_gap;
   int         recv_gap;

   // predictor state for the current word and line
   int          wlen;
   logic [7:0]  c_first;
   logic [7:0]  c_second;
   logic [7:0]  c_last;
   logic [25:0] kw_flags;
   longint      acc[4];
   longint      acc_prev[4];
   logic [3:0]  dig_ok;
   logic [3:0]  dig_ok_prev;
   int          slot_cnt;
   phase_type   phase;

   assembly_line_lexer dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end

   // predictor tables
   function automatic string mnem_word(int k);
      string s[26] = '{"clear", "ret", "jnat", "jmp", "call", "skpe", "skpne", "mov",
                       "add", "or", "and", "xor", "sub", "msr", "subs", "msl", "jv0",
                       "rand", "draw", "in", "hh5", "bcd", "movout", "movin", "dtm",
                       "stm"};
      return s[k];
   endfunction

   function automatic int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 16;
   endfunction

   function automatic int base_radix(int b);
      int r[4] = '{2, 8, 10, 16};
      return r[b];
   endfunction

   task automatic clear_word();
      wlen = 0;
      c_first = '0;
      c_second = '0;
      c_last = '0;
      kw_flags = '1;
      for (int b = 0; b < 4; b++) begin
         acc[b] = 0;
         acc_prev[b] = 0;
      end
      dig_ok = 4'hF;
      dig_ok_prev = 4'hF;
   endtask

   task automatic take_char(logic [7:0] c);
      string w;
      int d;
      longint v;
      d = hex_val(c);
      if (wlen == 0) c_first = c;
      if (wlen == 1) c_second = c;
      c_last = c;
      for (int k = 0; k < 26; k++) begin
         w = mnem_word(k);
         if (!(wlen < w.len() && w[wlen] == c)) kw_flags[k] = 1'b0;
      end
      dig_ok_prev = dig_ok;
      for (int b = 0; b < 4; b++) begin
         acc_prev[b] = acc[b];
         if (d < base_radix(b)) begin
            v = acc[b] * base_radix(b) + d;
            acc[b] = (v > 65535) ? 65536 : v;
         end else begin
            dig_ok[b] = 1'b0;
         end
      end
      if (wlen < 63) wlen++;
   endtask

   function automatic bit is_kw(int k);
      string w;
      w = mnem_word(k);
      return kw_flags[k] && w.len() == wlen;
   endfunction

   function automatic bit operand_kind(output logic [4:0] t, output logic [15:0] v);
      int b;
      longint a;
      bit ok;
      b = B_10;
      v = '0;
      t = T_INVALID;
      if (wlen == 2 && c_first == "v") begin
         if (hex_val(c_second) > 15) return 0;
         t = T_REG;
         v = 16'(hex_val(c_second));
         return 1;
      end
      if (wlen == 1 && c_first == "v") return 0;
      if (c_first == "I") begin
         t = T_INDEX;
         return 1;
      end
      if (is_kw(KW_DTM)) begin
         t = T_DTM;
         return 1;
      end
      if (is_kw(KW_STM)) begin
         t = T_STM;
         return 1;
      end
      if (c_last == "B") b = B_2;
      else if (c_last == "O") b = B_8;
      else if (c_last == "H") b = B_16;
      if (b == B_10) begin
         a = acc[b];
         ok = dig_ok[b];
      end else begin
         a = acc_prev[b];
         ok = dig_ok_prev[b];
      end
      if (!ok || a > 65535 || wlen > MAX_WORD_CHARS) return 0;
      t = T_CONST;
      v = a[15:0];
      return 1;
   endfunction

   task automatic push_token(logic [4:0] t, logic [15:0] v, int slot);
      result_type r;
      r = '0;
      r.token_type = t;
      r.token_value = v;
      r.token_slot = 3'(slot);
      expected_tokens.push_back(r);
   endtask

   // work out the results of one accepted character
   task automatic lex_char(logic [7:0] c, logic eos);
      bit sep;
      int found;
      logic [4:0] t;
      logic [15:0] v;
      result_type r;
      sep = (c == " " || c == ";" || c == "," || c == 8'h0A);
      if (!sep && phase != PH_DONE) take_char(c);
      if ((sep || eos) && wlen > 0) begin
         if (phase == PH_MNEM) begin
            found = NUM_MNEM;
            for (int k = 0; k < NUM_MNEM; k++)
               if (found == NUM_MNEM && is_kw(k)) found = k;
            if (found < NUM_MNEM) begin
               push_token(5'(found), '0, 0);
               slot_cnt = 1;
               phase = (slot_cnt >= MAX_LINE_TOKENS) ? PH_DONE : PH_OPER;
            end else begin
               push_token(T_INVALID, '0, 0);
               slot_cnt = 0;
               phase = PH_DONE;
            end
         end else if (phase == PH_OPER) begin
            if (operand_kind(t, v)) begin
               push_token(t, v, slot_cnt);
               slot_cnt++;
               if (slot_cnt >= MAX_LINE_TOKENS) phase = PH_DONE;
            end else begin
               push_token(T_INVALID, '0, slot_cnt);
               phase = PH_DONE;
            end
         end
         clear_word();
      end
      if (eos) begin
         if (phase == PH_MNEM) begin
            push_token(T_INVALID, '0, 0);
            slot_cnt = 0;
         end
         r = '0;
         r.kind = 1'b1;
         r.line_tokens = 4'(slot_cnt);
         r.last = 1'b1;
         expected_tokens.push_back(r);
         clear_word();
         slot_cnt = 0;
         phase = PH_MNEM;
      end
   endtask

   // stimulus building
   task automatic queue_line(string s);
      char_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.ch = s[i];
         it.eos = (i == s.len() - 1);
         pending_chars.push_back(it);
      end
      lines_sent++;
   endtask

   function automatic string rand_sep();
      string s[4] = '{" ", ";", ",", "\n"};
      string r;
      r = s[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) == 0) r = {r, s[$urandom_range(0, 3)]};
      return r;
   endfunction

   function automatic string rand_digits(string set, int n);
      string r;
      r = "";
      for (int i = 0; i < n; i++) r = {r, string'(set[$urandom_range(0, set.len() - 1)])};
      return r;
   endfunction

   function automatic string rand_operand();
      string hexd;
      string r;
      hexd = "0123456789ABCDEF";
      case ($urandom_range(0, 11))
         0, 1: r = {"v", string'(hexd[$urandom_range(0, 15)])};
         2: r = {"I", rand_digits("abcIv0", $urandom_range(0, 3))};
         3: r = ($urandom_range(0, 1) != 0) ? "dtm" : "stm";
         4: r = {rand_digits("01", $urandom_range(1, 18)), "B"};
         5: r = {rand_digits("01234567", $urandom_range(1, 7)), "O"};
         6: r = {rand_digits(hexd, $urandom_range(1, 5)), "H"};
         7, 8: r = rand_digits("0123456789", $urandom_range(1, 6));
         9: r = rand_digits("0123456789ABCDEFGvxO", $urandom_range(1, 4));
         10: r = ($urandom_range(0, 1) != 0) ? "v" : {"v", string'(8'($urandom_range(1, 255)))};
         default: r = rand_digits("0", $urandom_range(20, 30));
      endcase
      return r;
   endfunction

   // one random line; mostly well formed, some noise
   task automatic queue_random_line();
      string s;
      int nops;
      if ($urandom_range(0, 9) == 0) begin
         s = "";
         for (int i = 0; i < $urandom_range(1, 10); i++)
            s = {s, string'(8'($urandom_range(0, 255)))};
      end else begin
         if ($urandom_range(0, 7) == 0) s = rand_sep();
         else s = "";
         if ($urandom_range(0, 9) == 0) s = {s, rand_operand()};
         else s = {s, mnem_word($urandom_range(0, NUM_MNEM - 1))};
         nops = $urandom_range(0, 5);
         for (int i = 0; i < nops; i++) s = {s, rand_sep(), rand_operand()};
         if ($urandom_range(0, 3) == 0) s = {s, rand_sep()};
      end
      queue_line(s);
   endtask

   // driver: feeds pending characters, idles in random bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) chars_sent++;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 15) == 0) begin
               send_gap <= $urandom_range(0, 8);
               req_valid <= 1'b0;
            end else begin
               req_ch <= pending_chars[0].ch;
               req_end_of_string <= pending_chars[0].eos;
               lex_char(pending_chars[0].ch, pending_chars[0].eos);
               void'(pending_chars.pop_front());
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
         recv_gap <= $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare each result item with the oldest expectation
   always @(posedge clock) begin
      result_type exp_r;
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         got = '{rsp_kind, rsp_token_type, rsp_token_value, rsp_token_slot,
                 rsp_line_tokens, rsp_last};
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", got);
         end else begin
            exp_r = expected_tokens.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", exp_r, got);
            end
         end
      end
   end

   initial begin
      string directed[$];
      int spins;
      char_item_type nul_item;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch = 8'h00;
      req_end_of_string = 1'b0;
      rsp_stall = 1'b0;
      quiet_phase = 0;
      mismatches = 0;
      results_seen = 0;
      lines_sent = 0;
      chars_sent = 0;
      clear_word();
      slot_cnt = 0;
      phase = PH_MNEM;
      // directed lines: extremes and special cases
      directed = '{"mov vF,0FFFFH", "bogus v1", " ", "v", "add v,3", "jmp 65536",
                   "jmp 65535 777777O 1111111111111111B", "call I dtm stm 5",
                   "sub 19B;12", "or vG", "or 0000000000000000000000001", "ret H",
                   "draw \xff\x80 1"};
      foreach (directed[i]) queue_line(directed[i]);
      // a nul byte as the last word character of a line
      nul_item.eos = 1'b0;
      nul_item.ch = "i";
      pending_chars.push_back(nul_item);
      nul_item.ch = "n";
      pending_chars.push_back(nul_item);
      nul_item.ch = " ";
      pending_chars.push_back(nul_item);
      nul_item.ch = 8'h00;
      nul_item.eos = 1'b1;
      pending_chars.push_back(nul_item);
      lines_sent++;
      for (int k = 0; k < NUM_MNEM; k++) queue_line(mnem_word(k));
      while (chars_sent + pending_chars.size() < 1550) queue_random_line();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // last part of the run goes without idling
      while (pending_chars.size() > 60) @(posedge clock);
      quiet_phase = 1;
      while (pending_chars.size() > 0 || (req_valid && req_stall)) @(posedge clock);
      spins = 0;
      while (expected_tokens.size() > 0 && spins < 10000) begin
         @(posedge clock);
         spins++;
      end
      repeat (20) @(posedge clock);
      $display("covered %0d lines, %0d result items checked", lines_sent, results_seen);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  expected_tokens.size());
         $display("simulation failed");
      end
      $finish;
   end
endmodule
